[hdl/lcar_pkg.sv]
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared constants, codes and control types of the load cell converter reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcar_pkg;

    // Field and state widths
    localparam int DATA_BITS     = 24;
    localparam int TIMER_BITS    = 20;
    localparam int SUM_BITS      = 32;
    localparam int CNT_BITS      = 8;
    localparam int HALF_BITS     = 8;
    localparam int GAIN_BITS     = 2;
    localparam int PULSE_BITS    = 5;
    localparam int PHASE_BITS    = 2;
    localparam int KIND_BITS     = 2;
    localparam int VALUE_BITS    = 25;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

    // Stream and configuration port widths
    localparam int S_DATA_BITS   = 32;
    localparam int M_DATA_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    // Saturation bound of the reported value
    localparam logic signed [SUM_BITS:0] VAL_MAX = (SUM_BITS+1)'(16777215);

    // Request kinds
    localparam logic [KIND_BITS-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_MEASURE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TARE    = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_LOAD    = 2'd3;

    // Conversion phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_WAIT = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_HIGH = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_LOW  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVG     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PWRDN   = 3'd4;

    // Configuration reset values
    localparam logic [GAIN_BITS-1:0]  GAIN_RST    = 2'd1;
    localparam logic [HALF_BITS-1:0]  HALF_RST    = 8'd1;
    localparam logic [TIMER_BITS-1:0] TIMEOUT_RST = 20'd1000000;
    localparam logic [CNT_BITS-1:0]   AVG_RST     = 8'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic                shift_clear;
        logic                shift_en;
        logic                sum_clear;
        logic                sum_add;
        logic                conv_zero;
        logic                offset_load;
        logic                div_start;
        logic [CNT_BITS-1:0] divisor;
        logic                item_out;
        logic                final_out;
        logic                is_tare;
        logic                timed_out;
        logic                sck;
        logic                busy;
    } lcar_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic div_done;
    } lcar_status_t;

endpackage

`default_nettype wire

[hdl/load_cell_adc_reader.sv]
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Reader for a 24-bit two-wire load cell converter with averaging and tare.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the converter interface and yields one
// result transfer with the serial clock level and status for that tick. A
// plain tick is accepted every cycle while results are taken. The tick that
// completes the last conversion of a measure or tare request starts a
// one-bit-per-cycle divider over the 32-bit running sum; its result transfer
// is offered once the divider is done and the result register is free, and
// no tick is accepted before that result is loaded. The result register lets
// the next tick be accepted in the same cycle the previous result is taken.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_adc_reader import lcar_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input ticks
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_DATA_BITS-1:0]   s_tdata,   // dout[0], new_offset[24:1]
    input  wire logic [KIND_BITS-1:0]     s_tuser,   // kind[1:0]
    // per-tick results
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_DATA_BITS-1:0]        m_tdata,   // sck[0], busy_res[1], done_res[2],
                                                     // value[27:3], timed_out[28]
    // configuration writes
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    lcar_cmd_t    cmd;
    lcar_status_t status;

    lcar_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_kind    (s_tuser),
        .s_dout    (s_tdata[0]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    lcar_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_dout       (s_tdata[0]),
        .s_new_offset (s_tdata[DATA_BITS:1]),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/lcar_div.sv]
// ----------------------------------------------------------------------------
// lcar_div
// Signed by unsigned divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcar_div import lcar_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [SUM_BITS-1:0] dividend,
    input  wire logic [CNT_BITS-1:0] divisor,
    output logic                     done,
    output logic [SUM_BITS-1:0]      quotient
);

    logic                    active_reg, active_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]     rem_reg, rem_next;
    logic [SUM_BITS-1:0]     quo_reg, quo_next;
    logic [CNT_BITS-1:0]     den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [CNT_BITS:0]       trial;
    logic [CNT_BITS:0]       trial_sub;
    logic                    fits;

    // One restoring step
    assign trial     = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_BITS'(SUM_BITS - 1);
            rem_next    = '0;
            quo_next    = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            den_next    = divisor;
            neg_next    = dividend[SUM_BITS-1];
        end else if (active_reg) begin
            rem_next = fits ? trial_sub[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
            quo_next = {quo_reg[SUM_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Operands
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

[hdl/lcar_dp.sv]
// ----------------------------------------------------------------------------
// lcar_dp
// Datapath: shift register, running sum, offset, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcar_dp import lcar_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_dout,
    input  wire logic [DATA_BITS-1:0]   s_new_offset,
    input  wire lcar_cmd_t              cmd,
    output lcar_status_t                status,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_BITS-1:0]      m_tdata
);

    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SUM_BITS-1:0]    offset_reg, offset_next;
    logic [SUM_BITS-1:0]    conv_val;
    logic [SUM_BITS-1:0]    quotient;
    logic                   div_done;
    logic signed [SUM_BITS:0] q_ext, off_ext, diff;
    logic [VALUE_BITS-1:0]  value_sat;

    logic                   m_valid_reg, m_valid_next;
    logic                   sck_reg, busy_reg, done_reg, to_reg;
    logic [VALUE_BITS-1:0]  value_reg;

    // Serial word and running sum
    assign conv_val = cmd.conv_zero ? '0 :
                      {{(SUM_BITS-DATA_BITS){shift_reg[DATA_BITS-1]}}, shift_reg};

    always_comb begin
        shift_next = shift_reg;
        if (cmd.shift_clear) begin
            shift_next = '0;
        end else if (cmd.shift_en) begin
            shift_next = {shift_reg[DATA_BITS-2:0], s_dout};
        end
        sum_next = sum_reg;
        if (cmd.sum_clear) begin
            sum_next = '0;
        end else if (cmd.sum_add) begin
            sum_next = sum_reg + conv_val;
        end
    end

    lcar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_next),
        .divisor  (cmd.divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Final value: tare reports the average, measure the average minus offset
    assign q_ext   = {quotient[SUM_BITS-1], quotient};
    assign off_ext = {offset_reg[SUM_BITS-1], offset_reg};
    assign diff    = cmd.is_tare ? q_ext : (q_ext - off_ext);

    always_comb begin
        priority if (diff > VAL_MAX) begin
            value_sat = VAL_MAX[VALUE_BITS-1:0];
        end else if (diff < -VAL_MAX) begin
            value_sat = VALUE_BITS'(-VAL_MAX);
        end else begin
            value_sat = diff[VALUE_BITS-1:0];
        end
    end

    // Offset
    always_comb begin
        offset_next = offset_reg;
        if (cmd.offset_load) begin
            offset_next = {{(SUM_BITS-DATA_BITS){s_new_offset[DATA_BITS-1]}}, s_new_offset};
        end else if (cmd.final_out && cmd.is_tare) begin
            offset_next = quotient;
        end
    end

    // Result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.item_out || cmd.final_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            shift_reg   <= '0;
            offset_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            shift_reg   <= shift_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.item_out || cmd.final_out) begin
            sck_reg   <= cmd.sck;
            busy_reg  <= cmd.busy;
            done_reg  <= cmd.final_out;
            value_reg <= cmd.final_out ? value_sat : '0;
            to_reg    <= cmd.final_out & cmd.timed_out;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign status.div_done = div_done;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_BITS-VALUE_BITS-4)'(0), to_reg, value_reg,
                       done_reg, busy_reg, sck_reg};

endmodule

`default_nettype wire

[hdl/lcar_ctrl.sv]
// ----------------------------------------------------------------------------
// lcar_ctrl
// Controller: configuration registers, conversion phase machine, sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcar_ctrl import lcar_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [KIND_BITS-1:0]     s_kind,
    input  wire logic                     s_dout,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire lcar_status_t             status,
    output lcar_cmd_t                     cmd
);

    // Sequencer codes
    localparam logic [1:0] SQ_RUN    = 2'd0;
    localparam logic [1:0] SQ_DIV    = 2'd1;
    localparam logic [1:0] SQ_FINISH = 2'd2;

    logic [1:0]            seq_reg, seq_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [PULSE_BITS-1:0] pulse_reg, pulse_next;
    logic [CNT_BITS-1:0]   reads_reg, reads_next;
    logic                  tout_reg, tout_next;
    logic                  tare_reg, tare_next;

    logic [GAIN_BITS-1:0]  gain_reg;
    logic [HALF_BITS-1:0]  half_reg;
    logic [TIMER_BITS-1:0] timeout_reg;
    logic [CNT_BITS-1:0]   avg_reg;
    logic                  pd_reg;

    logic                  accept;
    logic [HALF_BITS-1:0]  half_eff;
    logic [CNT_BITS-1:0]   count_eff;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [PULSE_BITS-1:0] pulse_inc;
    logic [CNT_BITS-1:0]   reads_inc;
    logic                  conv_end;
    logic                  conv_zero;
    logic                  last_conv;
    logic                  shift_clear;
    logic                  shift_en;
    logic                  sum_clear;
    logic                  offset_load;

    assign half_eff  = (half_reg == '0) ? HALF_BITS'(1) : half_reg;
    assign count_eff = (avg_reg == '0) ? CNT_BITS'(1) : avg_reg;
    assign timer_inc = timer_reg + 1'b1;
    assign pulse_inc = pulse_reg + 1'b1;
    assign reads_inc = reads_reg + 1'b1;

    assign s_ready   = (seq_reg == SQ_RUN) && status.out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Conversion phase machine, one step per accepted tick
    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        pulse_next  = pulse_reg;
        reads_next  = reads_reg;
        tout_next   = tout_reg;
        tare_next   = tare_reg;
        conv_end    = 1'b0;
        conv_zero   = 1'b0;
        last_conv   = 1'b0;
        shift_clear = 1'b0;
        shift_en    = 1'b0;
        sum_clear   = 1'b0;
        offset_load = 1'b0;
        if (accept) begin
            if (pd_reg) begin
                phase_next = PH_IDLE;
                timer_next = '0;
                pulse_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (s_kind == KIND_LOAD) begin
                            offset_load = 1'b1;
                        end else if (s_kind == KIND_MEASURE || s_kind == KIND_TARE) begin
                            phase_next = PH_WAIT;
                            timer_next = '0;
                            pulse_next = '0;
                            reads_next = '0;
                            tout_next  = 1'b0;
                            tare_next  = (s_kind == KIND_TARE);
                            sum_clear  = 1'b1;
                        end
                    end
                    PH_WAIT: begin
                        if (!s_dout) begin
                            phase_next  = PH_HIGH;
                            timer_next  = '0;
                            pulse_next  = '0;
                            shift_clear = 1'b1;
                        end else begin
                            timer_next = timer_inc;
                            if (timer_inc >= timeout_reg) begin
                                tout_next = 1'b1;
                                conv_end  = 1'b1;
                                conv_zero = 1'b1;
                            end
                        end
                    end
                    PH_HIGH: begin
                        timer_next = timer_inc;
                        if (timer_inc >= TIMER_BITS'(half_eff)) begin
                            shift_en   = (pulse_reg < PULSE_BITS'(DATA_BITS));
                            phase_next = PH_LOW;
                            timer_next = '0;
                        end
                    end
                    PH_LOW: begin
                        timer_next = timer_inc;
                        if (timer_inc >= TIMER_BITS'(half_eff)) begin
                            timer_next = '0;
                            pulse_next = pulse_inc;
                            if ({1'b0, pulse_inc} >=
                                (PULSE_BITS+1)'(DATA_BITS) + (PULSE_BITS+1)'(gain_reg)) begin
                                conv_end = 1'b1;
                            end else begin
                                phase_next = PH_HIGH;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            // End of one conversion
            if (conv_end) begin
                reads_next = reads_inc;
                timer_next = '0;
                pulse_next = '0;
                if (reads_inc >= count_eff) begin
                    last_conv  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_WAIT;
                end
            end
        end
    end

    // Sequencer: hold off input while the average is divided out and until its result is loaded
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SQ_RUN: begin
                if (accept && last_conv) begin
                    seq_next = SQ_DIV;
                end
            end
            SQ_DIV: begin
                if (status.div_done) begin
                    seq_next = SQ_FINISH;
                end
            end
            SQ_FINISH: begin
                if (status.out_free) begin
                    seq_next = SQ_RUN;
                end
            end
            default: begin
                seq_next = SQ_RUN;
            end
        endcase
    end

    assign cmd.shift_clear = shift_clear;
    assign cmd.shift_en    = shift_en;
    assign cmd.sum_clear   = sum_clear;
    assign cmd.offset_load = offset_load;
    assign cmd.sum_add     = conv_end;
    assign cmd.conv_zero   = conv_zero;
    assign cmd.div_start   = accept && last_conv;
    assign cmd.divisor     = count_eff;
    assign cmd.item_out    = accept && !last_conv;
    assign cmd.final_out   = (seq_reg == SQ_FINISH) && status.out_free;
    assign cmd.is_tare     = tare_reg;
    assign cmd.timed_out   = tout_reg;
    assign cmd.sck         = pd_reg || (phase_next == PH_HIGH);
    assign cmd.busy        = (phase_next != PH_IDLE);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SQ_RUN;
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            pulse_reg <= '0;
            reads_reg <= '0;
            tout_reg  <= 1'b0;
            tare_reg  <= 1'b0;
        end else begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            pulse_reg <= pulse_next;
            reads_reg <= reads_next;
            tout_reg  <= tout_next;
            tare_reg  <= tare_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RST;
            half_reg    <= HALF_RST;
            timeout_reg <= TIMEOUT_RST;
            avg_reg     <= AVG_RST;
            pd_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GAIN:    gain_reg    <= cfg_data[GAIN_BITS-1:0];
                CFG_HALF:    half_reg    <= cfg_data[HALF_BITS-1:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMER_BITS-1:0];
                CFG_AVG:     avg_reg     <= cfg_data[CNT_BITS-1:0];
                CFG_PWRDN:   pd_reg      <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_div_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (seq_reg == SQ_DIV))
        else $error("divider start did not enter divide state");

    a_no_input_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg != SQ_RUN) |-> !s_ready)
        else $error("input ready while average pending");

    a_powerdown_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pd_reg) |-> (cmd.sck && !cmd.busy && !cmd.div_start))
        else $error("power-down tick not reported idle with sck high");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (seq_reg == SQ_DIV))
        else $error("divider finished outside divide state");

endmodule

`default_nettype wire
